[rtl/core/dq_pkg.sv]
// types and constants shared by the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    // default number of stored words
    localparam int unsigned DEPTH_DEFAULT = 16;

    // field widths fixed by the interface
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // one command transfer
    typedef struct packed {
        t_opcode                    opcode;
        logic signed [WORD_W-1:0]   push_value;
    } t_cmd;

    // one result transfer
    typedef struct packed {
        logic signed [WORD_W-1:0]   pop_value;
        t_status                    status;
        logic [COUNT_W-1:0]         element_count;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// double-ended queue of signed words kept in a ring buffer memory
//
//  channel   direction  handshake           payload
//  command   in         start / busy        i_cmd    (opcode, push_value)
//  result    out        o_strobe (1 cycle)  o_result (pop_value, status, element_count)
//
// one command per cycle while busy is low; its result shows in the cycle after the command transfer,
// the delay being the registered read port of the word memory
// pointer and count are updated at the transfer edge, so back-to-back commands
// see each other; a pop right after a push reads the memory after the push has written it
// busy is set by reset and cleared at the first clock edge out of reset, and the word memory is not cleared
// results cannot be stalled: o_strobe marks each for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire dq_pkg::t_cmd   i_cmd,
    output logic                o_strobe,
    output dq_pkg::t_result     o_result
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    // word memory
    logic [dq_pkg::WORD_W-1:0] r_mem [DEPTH];

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_busy;

    logic                      r_strobe;
    logic                      r_pop_ok;
    dq_pkg::t_status           r_status, n_status;
    logic [CW-1:0]             r_cnt_out;
    logic [dq_pkg::WORD_W-1:0] r_rd_data;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [SW-1:0] sum_tail;
    logic [SW-1:0] sum_rear;
    logic [AW-1:0] tail_pos;
    logic [AW-1:0] rear_pos;

    assign accept   = start && !busy;
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    // ring positions around the front pointer
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign sum_tail  = SW'(r_front) + SW'(r_count);
    assign sum_rear  = SW'(r_front) + SW'(r_count) - SW'(1);
    assign tail_pos  = (sum_tail >= DEPTH_S) ? AW'(sum_tail - DEPTH_S) : AW'(sum_tail);
    assign rear_pos  = (sum_rear >= DEPTH_S) ? AW'(sum_rear - DEPTH_S) : AW'(sum_rear);

    // command decode and pointer update
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = dq_pkg::ST_OK;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = tail_pos;
        rd_addr  = r_front;
        case (i_cmd.opcode)
            dq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    wr_en   = accept;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::OP_PUSH_REAR: begin
                if (is_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    wr_en   = accept;
                    wr_addr = tail_pos;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    rd_en   = accept;
                    rd_addr = r_front;
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            dq_pkg::OP_POP_REAR: begin
                if (is_empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    rd_en   = accept;
                    rd_addr = rear_pos;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = dq_pkg::ST_OK;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.push_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_pop_ok <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_front  <= n_front;
                r_count  <= n_count;
                r_pop_ok <= rd_en;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_cnt_out <= n_count;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

    always_comb begin
        o_result.pop_value     = r_pop_ok ? r_rd_data : '0;
        o_result.status        = r_status;
        o_result.element_count = dq_pkg::COUNT_W'(r_cnt_out);
    end

    // checks
    a_strobe_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe == $past(accept))
        else $error("result strobe without a command transfer");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count above depth");

    a_error_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (r_status != dq_pkg::ST_OK) |-> !r_pop_ok)
        else $error("error result carries a popped word");

    a_error_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (n_status != dq_pkg::ST_OK) |=> $stable(r_count) && $stable(r_front))
        else $error("failed command changed the queue state");

endmodule

`default_nettype wire
